// ===== rtl/svwe_pkg.sv =====
// Shared types and constants of the stack machine word executor.
`timescale 1ns / 1ps

package svwe_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CODE_WIDTH = 3;
   localparam int NUM_REGS   = 6;
   localparam int REG_IDX_WIDTH = 3;

   localparam logic [WORD_WIDTH-1:0] OP_PSH   = 32'd0;
   localparam logic [WORD_WIDTH-1:0] OP_ADD   = 32'd1;
   localparam logic [WORD_WIDTH-1:0] OP_POP   = 32'd2;
   localparam logic [WORD_WIDTH-1:0] OP_SET   = 32'd3;
   localparam logic [WORD_WIDTH-1:0] OP_PRINT = 32'd4;
   localparam logic [WORD_WIDTH-1:0] OP_HLT   = 32'd6;

   localparam logic [CODE_WIDTH-1:0] RC_PRINT     = 3'd0;
   localparam logic [CODE_WIDTH-1:0] RC_HALT      = 3'd1;
   localparam logic [CODE_WIDTH-1:0] RC_OVERFLOW  = 3'd2;
   localparam logic [CODE_WIDTH-1:0] RC_UNDERFLOW = 3'd3;
   localparam logic [CODE_WIDTH-1:0] RC_BADREG    = 3'd4;

   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_ABOVE = 2'd1;
   localparam logic [1:0] CELL_BELOW = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
      logic add;
   } stack_cmd_type;

endpackage

// ===== rtl/svwe_cell.sv =====
// One stack entry cell: holds, takes its upper neighbor, or takes its lower neighbor.
`timescale 1ns / 1ps

module svwe_cell
   import svwe_pkg::*;
(
   input  logic                    clock,
   input  logic [1:0]              cmd,
   input  logic [WORD_WIDTH-1:0]   data_above,
   input  logic [WORD_WIDTH-1:0]   data_below,
   output logic [WORD_WIDTH-1:0]   data_out
);

   logic [WORD_WIDTH-1:0] entry_ff;
   logic [WORD_WIDTH-1:0] entry_in;

   always_comb begin
      case (cmd)
         CELL_ABOVE: entry_in = data_above;
         CELL_BELOW: entry_in = data_below;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_out = entry_ff;

endmodule

// ===== rtl/svwe_decode.sv =====
// Word decoder: phase, general registers, stack count, halt flag and result register.
`timescale 1ns / 1ps

module svwe_decode
   import svwe_pkg::*;
#(
   parameter int STACK_DEPTH = 256
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [WORD_WIDTH-1:0]   word,
   input  logic [WORD_WIDTH-1:0]   top_entry,
   output stack_cmd_type           stack_cmd,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [CODE_WIDTH-1:0]   result_code,
   output logic [WORD_WIDTH-1:0]   value
);

   localparam int CNT_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(STACK_DEPTH);
   localparam logic [CNT_WIDTH-1:0] CNT_ONE  = CNT_WIDTH'(1);
   localparam logic [CNT_WIDTH-1:0] CNT_TWO  = CNT_WIDTH'(2);

   localparam logic [2:0] PH_OPCODE    = 3'd0;
   localparam logic [2:0] PH_PSH_VAL   = 3'd1;
   localparam logic [2:0] PH_POP_REG   = 3'd2;
   localparam logic [2:0] PH_SET_REG   = 3'd3;
   localparam logic [2:0] PH_SET_VAL   = 3'd4;
   localparam logic [2:0] PH_PRINT_REG = 3'd5;
   localparam logic [2:0] PH_SET_SKIP  = 3'd6;

   logic [2:0]                  phase_ff, phase_in;
   logic [REG_IDX_WIDTH-1:0]    pend_ff, pend_in;
   logic [WORD_WIDTH-1:0]       regs_ff [NUM_REGS];
   logic [WORD_WIDTH-1:0]       regs_in [NUM_REGS];
   logic [CNT_WIDTH-1:0]        count_ff, count_in;
   logic                        halted_ff, halted_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CODE_WIDTH-1:0]       code_ff, code_in;
   logic [WORD_WIDTH-1:0]       value_ff, value_in;

   logic                        fire;
   logic                        reg_ok;
   logic [REG_IDX_WIDTH-1:0]    widx;
   logic                        emit;
   logic [CODE_WIDTH-1:0]       emit_code;
   logic [WORD_WIDTH-1:0]       emit_value;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign widx       = word[REG_IDX_WIDTH-1:0];
   assign reg_ok     = (word[WORD_WIDTH-1:REG_IDX_WIDTH] == '0) &&
                       (widx < REG_IDX_WIDTH'(NUM_REGS));

   always_comb begin
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      regs_in    = regs_ff;
      count_in   = count_ff;
      halted_in  = halted_ff;
      stack_cmd  = '0;
      emit       = 1'b0;
      emit_code  = RC_PRINT;
      emit_value = '0;
      if (fire && !halted_ff) begin
         phase_in = PH_OPCODE;
         unique case (phase_ff)
            PH_OPCODE: begin
               unique case (word)
                  OP_PSH:   phase_in = PH_PSH_VAL;
                  OP_ADD: begin
                     if (count_ff < CNT_TWO) begin
                        emit      = 1'b1;
                        emit_code = RC_UNDERFLOW;
                     end else begin
                        stack_cmd.add = 1'b1;
                        count_in      = count_ff - CNT_ONE;
                     end
                  end
                  OP_POP:   phase_in = PH_POP_REG;
                  OP_SET:   phase_in = PH_SET_REG;
                  OP_PRINT: phase_in = PH_PRINT_REG;
                  OP_HLT: begin
                     halted_in = 1'b1;
                     emit      = 1'b1;
                     emit_code = RC_HALT;
                  end
                  default: ;
               endcase
            end
            PH_PSH_VAL: begin
               if (count_ff == CNT_FULL) begin
                  emit      = 1'b1;
                  emit_code = RC_OVERFLOW;
               end else begin
                  stack_cmd.push = 1'b1;
                  count_in       = count_ff + CNT_ONE;
               end
            end
            PH_POP_REG: begin
               if (!reg_ok) begin
                  emit      = 1'b1;
                  emit_code = RC_BADREG;
               end else if (count_ff == '0) begin
                  emit      = 1'b1;
                  emit_code = RC_UNDERFLOW;
               end else begin
                  stack_cmd.pop = 1'b1;
                  count_in      = count_ff - CNT_ONE;
                  regs_in[widx] = top_entry;
               end
            end
            PH_SET_REG: begin
               if (!reg_ok) begin
                  phase_in  = PH_SET_SKIP;
                  emit      = 1'b1;
                  emit_code = RC_BADREG;
               end else begin
                  pend_in  = widx;
                  phase_in = PH_SET_VAL;
               end
            end
            PH_SET_VAL: begin
               if (pend_ff < REG_IDX_WIDTH'(NUM_REGS)) begin
                  regs_in[pend_ff] = word;
               end
            end
            PH_PRINT_REG: begin
               emit = 1'b1;
               if (!reg_ok) begin
                  emit_code = RC_BADREG;
               end else begin
                  emit_code  = RC_PRINT;
                  emit_value = regs_ff[widx];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      value_in     = value_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
         code_in      = emit_code;
         value_in     = emit_value;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         pend_ff      <= '0;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      value_ff <= value_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign result_code = code_ff;
   assign value       = value_ff;

endmodule

// ===== rtl/stack_vm_word_executor.sv =====
// Top level of the stack machine word executor: decoder plus a chain of stack cells.
`timescale 1ns / 1ps

// Executes a stream of 32-bit program words of a small stack machine (PSH, ADD, POP,
// SET, PRINT, HLT) and returns one item for each print, halt or error. Back-to-back
// words are accepted without gaps; the only stall comes from the registered result
// stage when a result is waiting and rsp_tready is low. The stack is a row of
// STACK_DEPTH cells that shift together on push and pop, with the top in the first
// cell, so ADD reads both operands at once. No clearing pass after reset; an empty
// stack is tracked by a count.

module stack_vm_word_executor
   import svwe_pkg::*;
#(
   parameter int STACK_DEPTH = 256
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] word
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata    // [2:0] result_code, [34:3] value, [39:35] zero
);

   stack_cmd_type          stack_cmd;
   logic [CODE_WIDTH-1:0]  result_code;
   logic [WORD_WIDTH-1:0]  value;
   logic [WORD_WIDTH-1:0]  entry   [STACK_DEPTH+1];
   logic [1:0]             cell_cmd [STACK_DEPTH];
   logic [WORD_WIDTH-1:0]  sum;
   logic [WORD_WIDTH-1:0]  head_above;

   svwe_decode #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .word        (req_tdata),
      .top_entry   (entry[0]),
      .stack_cmd   (stack_cmd),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .result_code (result_code),
      .value       (value)
   );

   assign sum        = entry[1] + entry[0];
   assign head_above = stack_cmd.push ? req_tdata : sum;
   assign entry[STACK_DEPTH] = '0;

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cell_cmd[i] = CELL_HOLD;
         if (stack_cmd.push) begin
            cell_cmd[i] = CELL_ABOVE;
         end else if (stack_cmd.pop) begin
            cell_cmd[i] = CELL_BELOW;
         end else if (stack_cmd.add) begin
            cell_cmd[i] = (i == 0) ? CELL_ABOVE : CELL_BELOW;
         end
      end
   end

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      svwe_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd[g]),
         .data_above ((g == 0) ? head_above : entry[(g == 0) ? 0 : g-1]),
         .data_below (entry[g+1]),
         .data_out   (entry[g])
      );
   end

   assign rsp_tdata = {5'b0, value, result_code};

endmodule
